### sv/rbi_pkg.sv
// Shared constants and types for the rigid body integration pipeline.
package rbi_pkg;

  // Default vector component format (signed Q10.10).
  localparam int unsigned COMPONENT_BITS_DEF = 20;
  localparam int unsigned FRACTION_BITS_DEF  = 10;

  // Fixed field widths of the body record.
  localparam int unsigned DT_W     = 16;
  localparam int unsigned DAMP_W   = 17;
  localparam int unsigned LIM_W    = 19;
  localparam int unsigned LOCK_W   = 6;
  localparam int unsigned CFG_IDX_W = 3;

  // Extra fraction bits squared into the length before the square root.
  localparam int unsigned SQ_SH = 16;

  // Reset step: about 1/60 s in Q0.16.
  localparam logic [DT_W-1:0] TIME_STEP_RST = 16'd1092;

  typedef enum logic [1:0] {
    MODE_STATIC    = 2'd0,
    MODE_DYNAMIC   = 2'd1,
    MODE_KINEMATIC = 2'd2
  } mode_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_EN  = 3'd4;

endpackage

### sv/rbi_intf.sv
// Valid/ready channel interfaces for body records and integration results.
interface rbi_body_if #(
  parameter int unsigned CB = rbi_pkg::COMPONENT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic                        body_active;
  logic                        gravity_on;
  logic [3*CB-1:0]             linear_velocity;
  logic [3*CB-1:0]             angular_velocity;
  logic [3*CB-1:0]             position;
  logic [3*CB-1:0]             rotation;
  logic [rbi_pkg::DAMP_W-1:0]  linear_damping;
  logic [rbi_pkg::DAMP_W-1:0]  angular_damping;
  logic [rbi_pkg::LIM_W-1:0]   max_linear_speed;
  logic [rbi_pkg::LIM_W-1:0]   max_angular_speed;
  logic [rbi_pkg::LOCK_W-1:0]  lock_mask;

  modport source (
    output valid, mode, body_active, gravity_on, linear_velocity, angular_velocity,
           position, rotation, linear_damping, angular_damping, max_linear_speed,
           max_angular_speed, lock_mask,
    input  ready
  );
  modport sink (
    input  valid, mode, body_active, gravity_on, linear_velocity, angular_velocity,
           position, rotation, linear_damping, angular_damping, max_linear_speed,
           max_angular_speed, lock_mask,
    output ready
  );
endinterface

interface rbi_result_if #(
  parameter int unsigned CB = rbi_pkg::COMPONENT_BITS_DEF
);
  logic            valid;
  logic            ready;
  logic [3*CB-1:0] new_linear_velocity;
  logic [3*CB-1:0] new_angular_velocity;
  logic [3*CB-1:0] new_position;
  logic [3*CB-1:0] new_rotation;
  logic            asleep;
  logic            moved;
  logic            updated;

  modport source (
    output valid, new_linear_velocity, new_angular_velocity, new_position,
           new_rotation, asleep, moved, updated,
    input  ready
  );
  modport sink (
    input  valid, new_linear_velocity, new_angular_velocity, new_position,
           new_rotation, asleep, moved, updated,
    output ready
  );
endinterface

### sv/rigid_body_integrate_step.sv
// Pipelined semi-implicit Euler integrator for one rigid body per transfer.
//
// One body record enters per cycle while the output is not stalled, and its
// updated state leaves in order. Most of the stages serve the speed clamp:
// the vector length comes from a square root that resolves two root bits
// per stage, and each clamped component from a divider that resolves two
// quotient bits per stage; both run for the linear and angular vector side
// by side. The whole pipeline holds while a finished result waits at the
// output register and the sink is not ready; bubbles inside the pipe hold
// with it and are not squeezed out.
// Gravity, the time step and the sleep enable come from the write port and
// must only be written while no body is in flight. Dynamic bodies get
// gravity, damping, speed clamp, axis locks, pose integration and the sleep
// test; static bodies get zero velocities and go to sleep; kinematic bodies
// only get their locked axes zeroed; inactive bodies and a zero time step pass
// the record through with updated low.
module rigid_body_integrate_step #(
  parameter int unsigned COMPONENT_BITS = rbi_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned FRACTION_BITS  = rbi_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rbi_body_if.sink                        body_i,
  rbi_result_if.source                    result_o,
  input  logic                            cfg_we_i,
  input  logic [rbi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [((COMPONENT_BITS > rbi_pkg::DT_W) ? COMPONENT_BITS : rbi_pkg::DT_W)-1:0]
                                          cfg_data_i
);

  localparam int unsigned CB     = COMPONENT_BITS;
  localparam int unsigned F      = FRACTION_BITS;
  localparam int unsigned DT_W   = rbi_pkg::DT_W;
  localparam int unsigned DAMP_W = rbi_pkg::DAMP_W;
  localparam int unsigned LIM_W  = rbi_pkg::LIM_W;
  localparam int unsigned SQ_SH  = rbi_pkg::SQ_SH;

  // Arithmetic widths.
  localparam int unsigned GPW = CB + DT_W + 1;                       // v*dt product
  localparam int unsigned DCW = (F + 7 > DAMP_W) ? F + 7 : DAMP_W;   // capped damping
  localparam int unsigned DDW = DCW + DT_W;                          // d*dt
  localparam int unsigned SCW = F + DT_W + 1;                        // damping scale
  localparam int unsigned DPW = CB + SCW + 1;                        // v*scale
  localparam int unsigned SQW = 2 * CB;                              // one square
  localparam int unsigned SSW = SQW + 2;                             // sum of squares
  localparam int unsigned LSW = 2 * LIM_W;                           // limit squared
  localparam int unsigned CMW = (SSW > LSW) ? SSW : LSW;
  localparam int unsigned RW  = CB + SQ_SH / 2;                      // root bits
  localparam int unsigned NSQ = (RW + 1) / 2;                        // root stages
  localparam int unsigned RTW = 2 * NSQ;
  localparam int unsigned XPW = 2 * RTW;
  localparam int unsigned RMW = RTW + 2;
  localparam int unsigned MLW = CB + LIM_W;                          // |v|*limit
  localparam int unsigned NW  = MLW + SQ_SH / 2 + 2;                 // dividend
  localparam int unsigned NDV = (CB + 1) / 2;                        // divider stages
  localparam int unsigned QB  = 2 * NDV;
  localparam int unsigned DW  = RTW + 1;                             // divisor 2*len
  localparam int unsigned CW4 = CB + 4;

  // Stage indexes.
  localparam int unsigned S_IN  = 0;
  localparam int unsigned S_GM  = 1;
  localparam int unsigned S_GA  = 2;
  localparam int unsigned S_DM  = 3;
  localparam int unsigned S_DR  = 4;
  localparam int unsigned S_SQ  = 5;
  localparam int unsigned S_SUM = 6;
  localparam int unsigned S_RT0 = 7;
  localparam int unsigned S_ML  = S_RT0 + NSQ;
  localparam int unsigned S_NUM = S_ML + 1;
  localparam int unsigned S_DV0 = S_NUM + 1;
  localparam int unsigned S_FIX = S_DV0 + NDV;
  localparam int unsigned S_IM  = S_FIX + 1;
  localparam int unsigned S_OUT = S_IM + 1;
  localparam int unsigned NST   = S_OUT + 1;

  localparam logic signed [CW4-1:0] C_MAX = CW4'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [CW4-1:0] C_MIN = -C_MAX - CW4'(1);
  localparam logic [DCW-1:0]        DAMP_CAP = DCW'(64'd100 << F);
  localparam logic [DDW-1:0]        ONE_SC   = DDW'(64'd1 << (F + DT_W));
  localparam logic signed [GPW:0]   HALF_DT  = (GPW + 1)'(1) << (DT_W - 1);
  localparam logic signed [DPW:0]   HALF_DP  = (DPW + 1)'(1) << (F + DT_W - 1);
  localparam longint unsigned       SLOW_L   = ((64'd1 << (2 * F)) + 64'd9999) / 64'd10000;
  localparam logic [SSW-1:0]        SLOW_THR = SSW'(SLOW_L);
  // -9.81 m/s^2 in the component format.
  localparam longint                GRAV_Y_L = -((981 * (64'sd1 <<< F) + 50) / 100);
  localparam logic signed [CB-1:0]  GRAV_Y_RST = CB'(GRAV_Y_L);

  // Index 0 is the linear vector, index 1 the angular one.
  typedef struct {
    logic [1:0]              mode;
    logic                    act;
    logic                    gon;
    logic [5:0]              locks;
    logic signed [CB-1:0]    ov    [2][3];
    logic signed [CB-1:0]    w     [2][3];
    logic signed [CB-1:0]    pose  [2][3];
    logic [DAMP_W-1:0]       damp  [2];
    logic [LIM_W-1:0]        lim   [2];
    logic signed [GPW-1:0]   prod  [2][3];
    logic [DDW-1:0]          dd    [2];
    logic [SCW-1:0]          scale [2];
    logic signed [DPW-1:0]   dp    [2][3];
    logic [SQW-1:0]          sq    [2][3];
    logic [LSW-1:0]          limsq [2];
    logic                    zero  [2];
    logic                    keep  [2];
    logic [XPW-1:0]          x     [2];
    logic [RMW-1:0]          rrem  [2];
    logic [RTW-1:0]          root  [2];
    logic [MLW-1:0]          ml    [2][3];
    logic [QB-1:0]           dnum  [2][3];
    logic [DW-1:0]           drem  [2][3];
    logic [QB-1:0]           dq    [2][3];
    logic                    asleep;
    logic                    moved;
    logic                    upd;
  } pl_t;

  function automatic logic signed [CB-1:0] sat_c(input logic signed [CW4-1:0] v);
    if (v > C_MAX) return CB'(C_MAX);
    if (v < C_MIN) return CB'(C_MIN);
    return CB'(v);
  endfunction

  // Round a value*dt product back to the component format (ties up).
  function automatic logic signed [CW4-1:0] rnd_dt(input logic signed [GPW-1:0] p);
    logic signed [GPW:0] t;
    t = (GPW + 1)'(p) + HALF_DT;
    return CW4'(t >>> DT_W);
  endfunction

  // Configuration registers.
  logic signed [CB-1:0] grav_q [3];
  logic [DT_W-1:0]      dt_q;
  logic                 sleep_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0]  <= '0;
      grav_q[1]  <= GRAV_Y_RST;
      grav_q[2]  <= '0;
      dt_q       <= rbi_pkg::TIME_STEP_RST;
      sleep_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbi_pkg::REG_GRAV_X:    grav_q[0]  <= cfg_data_i[CB-1:0];
        rbi_pkg::REG_GRAV_Y:    grav_q[1]  <= cfg_data_i[CB-1:0];
        rbi_pkg::REG_GRAV_Z:    grav_q[2]  <= cfg_data_i[CB-1:0];
        rbi_pkg::REG_TIME_STEP: dt_q       <= cfg_data_i[DT_W-1:0];
        rbi_pkg::REG_SLEEP_EN:  sleep_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline registers: valid bits are reset, payload is not.
  logic [NST-1:0] v_q;
  pl_t            st_q [NST];
  pl_t            st_d [NST];
  logic           en;

  // Advance everything unless the output register holds an untaken result.
  assign en           = !v_q[S_OUT] || result_o.ready;
  assign body_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], body_i.valid};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Capture the body record.
  always_comb begin
    st_d[S_IN] = st_q[S_IN];
    st_d[S_IN].mode  = body_i.mode;
    st_d[S_IN].act   = body_i.body_active;
    st_d[S_IN].gon   = body_i.gravity_on;
    st_d[S_IN].locks = body_i.lock_mask;
    for (int i = 0; i < 3; i++) begin
      st_d[S_IN].ov[0][i]   = body_i.linear_velocity[i*CB +: CB];
      st_d[S_IN].ov[1][i]   = body_i.angular_velocity[i*CB +: CB];
      st_d[S_IN].w[0][i]    = body_i.linear_velocity[i*CB +: CB];
      st_d[S_IN].w[1][i]    = body_i.angular_velocity[i*CB +: CB];
      st_d[S_IN].pose[0][i] = body_i.position[i*CB +: CB];
      st_d[S_IN].pose[1][i] = body_i.rotation[i*CB +: CB];
    end
    st_d[S_IN].damp[0] = body_i.linear_damping;
    st_d[S_IN].damp[1] = body_i.angular_damping;
    st_d[S_IN].lim[0]  = body_i.max_linear_speed;
    st_d[S_IN].lim[1]  = body_i.max_angular_speed;
  end

  // Gravity impulse and damping products.
  always_comb begin
    logic [DCW-1:0] dc;
    st_d[S_GM] = st_q[S_GM-1];
    for (int i = 0; i < 3; i++) begin
      st_d[S_GM].prod[0][i] = GPW'(grav_q[i]) * GPW'($signed({1'b0, dt_q}));
    end
    for (int v = 0; v < 2; v++) begin
      dc = (DCW'(st_q[S_GM-1].damp[v]) > DAMP_CAP) ? DAMP_CAP : DCW'(st_q[S_GM-1].damp[v]);
      st_d[S_GM].dd[v] = DDW'(dc) * DDW'(dt_q);
    end
  end

  // Add gravity to the linear velocity; form the damping scale floored at zero.
  always_comb begin
    st_d[S_GA] = st_q[S_GA-1];
    if (st_q[S_GA-1].gon) begin
      for (int i = 0; i < 3; i++) begin
        st_d[S_GA].w[0][i] = sat_c(CW4'(st_q[S_GA-1].w[0][i]) +
                                   rnd_dt(st_q[S_GA-1].prod[0][i]));
      end
    end
    for (int v = 0; v < 2; v++) begin
      st_d[S_GA].scale[v] = (st_q[S_GA-1].dd[v] < ONE_SC) ?
                            SCW'(ONE_SC - st_q[S_GA-1].dd[v]) : '0;
    end
  end

  // Damping multiply.
  always_comb begin
    st_d[S_DM] = st_q[S_DM-1];
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        st_d[S_DM].dp[v][i] = DPW'(st_q[S_DM-1].w[v][i]) *
                              DPW'($signed({1'b0, st_q[S_DM-1].scale[v]}));
      end
    end
  end

  // Round the damped velocity back.
  always_comb begin
    logic signed [DPW:0] t;
    st_d[S_DR] = st_q[S_DR-1];
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        t = (DPW + 1)'(st_q[S_DR-1].dp[v][i]) + HALF_DP;
        st_d[S_DR].w[v][i] = CB'(t >>> (F + DT_W));
      end
    end
  end

  // Squares of the components and of the limits.
  always_comb begin
    logic signed [SQW-1:0] p;
    st_d[S_SQ] = st_q[S_SQ-1];
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        p = SQW'(st_q[S_SQ-1].w[v][i]) * SQW'(st_q[S_SQ-1].w[v][i]);
        st_d[S_SQ].sq[v][i] = p;
      end
      st_d[S_SQ].limsq[v] = LSW'(st_q[S_SQ-1].lim[v]) * LSW'(st_q[S_SQ-1].lim[v]);
    end
  end

  // Sum of squares, clamp decision, and square root setup.
  always_comb begin
    logic [SSW-1:0] s;
    st_d[S_SUM] = st_q[S_SUM-1];
    for (int v = 0; v < 2; v++) begin
      s = SSW'(st_q[S_SUM-1].sq[v][0]) + SSW'(st_q[S_SUM-1].sq[v][1]) +
          SSW'(st_q[S_SUM-1].sq[v][2]);
      st_d[S_SUM].zero[v] = (st_q[S_SUM-1].lim[v] == '0);
      st_d[S_SUM].keep[v] = (CMW'(s) <= CMW'(st_q[S_SUM-1].limsq[v]));
      st_d[S_SUM].x[v]    = XPW'(s) << SQ_SH;
      st_d[S_SUM].rrem[v] = '0;
      st_d[S_SUM].root[v] = '0;
    end
  end

  // Square root, two root bits per stage.
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    always_comb begin
      logic [RMW-1:0] r2;
      logic [RMW-1:0] tr;
      logic [RMW-1:0] rem;
      logic [RTW-1:0] root;
      logic [XPW-1:0] x;
      st_d[S_RT0+j] = st_q[S_RT0+j-1];
      for (int v = 0; v < 2; v++) begin
        rem  = st_q[S_RT0+j-1].rrem[v];
        root = st_q[S_RT0+j-1].root[v];
        x    = st_q[S_RT0+j-1].x[v];
        for (int b = 0; b < 2; b++) begin
          r2 = {rem[RMW-3:0], x[XPW-1 -: 2]};
          tr = {root, 2'b01};
          if (r2 >= tr) begin
            rem  = r2 - tr;
            root = {root[RTW-2:0], 1'b1};
          end else begin
            rem  = r2;
            root = {root[RTW-2:0], 1'b0};
          end
          x = x << 2;
        end
        st_d[S_RT0+j].rrem[v] = rem;
        st_d[S_RT0+j].root[v] = root;
        st_d[S_RT0+j].x[v]    = x;
      end
    end
  end

  // |component| * limit.
  always_comb begin
    logic [CB-1:0] mg;
    st_d[S_ML] = st_q[S_ML-1];
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        mg = st_q[S_ML-1].w[v][i][CB-1] ? CB'(-st_q[S_ML-1].w[v][i]) :
                                          CB'(st_q[S_ML-1].w[v][i]);
        st_d[S_ML].ml[v][i] = MLW'(mg) * MLW'(st_q[S_ML-1].lim[v]);
      end
    end
  end

  // Dividend with rounding term; the upper part seeds the remainder.
  always_comb begin
    logic [NW-1:0] n;
    st_d[S_NUM] = st_q[S_NUM-1];
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        n = (NW'(st_q[S_NUM-1].ml[v][i]) << (SQ_SH / 2 + 1)) +
            NW'(st_q[S_NUM-1].root[v]);
        st_d[S_NUM].drem[v][i] = DW'(n >> QB);
        st_d[S_NUM].dnum[v][i] = n[QB-1:0];
        st_d[S_NUM].dq[v][i]   = '0;
      end
    end
  end

  // Restoring division by twice the length, two quotient bits per stage.
  for (genvar j = 0; j < NDV; j++) begin : g_div
    always_comb begin
      logic [DW:0]   r2;
      logic [DW:0]   dv;
      logic [DW-1:0] rem;
      logic [QB-1:0] num;
      logic [QB-1:0] q;
      st_d[S_DV0+j] = st_q[S_DV0+j-1];
      for (int v = 0; v < 2; v++) begin
        dv = {1'b0, st_q[S_DV0+j-1].root[v], 1'b0};
        for (int i = 0; i < 3; i++) begin
          rem = st_q[S_DV0+j-1].drem[v][i];
          num = st_q[S_DV0+j-1].dnum[v][i];
          q   = st_q[S_DV0+j-1].dq[v][i];
          for (int b = 0; b < 2; b++) begin
            r2 = {rem, num[QB-1]};
            if (r2 >= dv) begin
              rem = DW'(r2 - dv);
              q   = {q[QB-2:0], 1'b1};
            end else begin
              rem = DW'(r2);
              q   = {q[QB-2:0], 1'b0};
            end
            num = num << 1;
          end
          st_d[S_DV0+j].drem[v][i] = rem;
          st_d[S_DV0+j].dnum[v][i] = num;
          st_d[S_DV0+j].dq[v][i]   = q;
        end
      end
    end
  end

  // Apply the clamp result, then the axis locks.
  always_comb begin
    logic signed [CW4-1:0] qs;
    logic signed [CW4-1:0] c;
    st_d[S_FIX] = st_q[S_FIX-1];
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        qs = CW4'($signed({1'b0, st_q[S_FIX-1].dq[v][i]}));
        if (st_q[S_FIX-1].zero[v]) begin
          c = '0;
        end else if (st_q[S_FIX-1].keep[v]) begin
          c = CW4'(st_q[S_FIX-1].w[v][i]);
        end else begin
          c = st_q[S_FIX-1].w[v][i][CB-1] ? -qs : qs;
        end
        if (st_q[S_FIX-1].locks[v*3+i]) begin
          c = '0;
        end
        st_d[S_FIX].w[v][i] = sat_c(c);
      end
    end
  end

  // Pose increments and squares for the sleep test.
  always_comb begin
    logic signed [SQW-1:0] p;
    st_d[S_IM] = st_q[S_IM-1];
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        st_d[S_IM].prod[v][i] = GPW'(st_q[S_IM-1].w[v][i]) * GPW'($signed({1'b0, dt_q}));
        p = SQW'(st_q[S_IM-1].w[v][i]) * SQW'(st_q[S_IM-1].w[v][i]);
        st_d[S_IM].sq[v][i] = p;
      end
    end
  end

  // Integrate the pose and pick the result by body kind.
  always_comb begin
    logic [SSW-1:0]       s;
    logic                 slow [2];
    logic signed [CB-1:0] np [2][3];
    st_d[S_OUT] = st_q[S_OUT-1];
    for (int v = 0; v < 2; v++) begin
      s = SSW'(st_q[S_OUT-1].sq[v][0]) + SSW'(st_q[S_OUT-1].sq[v][1]) +
          SSW'(st_q[S_OUT-1].sq[v][2]);
      slow[v] = (s < SLOW_THR);
      for (int i = 0; i < 3; i++) begin
        np[v][i] = sat_c(CW4'(st_q[S_OUT-1].pose[v][i]) + rnd_dt(st_q[S_OUT-1].prod[v][i]));
      end
    end
    st_d[S_OUT].asleep = 1'b0;
    st_d[S_OUT].moved  = 1'b0;
    st_d[S_OUT].upd    = st_q[S_OUT-1].act && (dt_q != '0);
    if (!st_d[S_OUT].upd) begin
      st_d[S_OUT].w = st_q[S_OUT-1].ov;
    end else begin
      case (st_q[S_OUT-1].mode)
        rbi_pkg::MODE_STATIC: begin
          for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
              st_d[S_OUT].w[v][i] = '0;
            end
          end
          st_d[S_OUT].asleep = 1'b1;
        end
        rbi_pkg::MODE_DYNAMIC: begin
          st_d[S_OUT].pose   = np;
          st_d[S_OUT].moved  = 1'b1;
          st_d[S_OUT].asleep = sleep_en_q && slow[0] && slow[1];
        end
        default: begin
          // Kinematic, and the unused code treated as kinematic: locks only.
          for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < 3; i++) begin
              st_d[S_OUT].w[v][i] = st_q[S_OUT-1].locks[v*3+i] ? '0 :
                                    st_q[S_OUT-1].ov[v][i];
            end
          end
        end
      endcase
    end
  end

  // Output register is the last stage.
  assign result_o.valid = v_q[S_OUT];
  for (genvar i = 0; i < 3; i++) begin : g_pack
    assign result_o.new_linear_velocity[i*CB +: CB]  = st_q[S_OUT].w[0][i];
    assign result_o.new_angular_velocity[i*CB +: CB] = st_q[S_OUT].w[1][i];
    assign result_o.new_position[i*CB +: CB]         = st_q[S_OUT].pose[0][i];
    assign result_o.new_rotation[i*CB +: CB]         = st_q[S_OUT].pose[1][i];
  end
  assign result_o.asleep  = st_q[S_OUT].asleep;
  assign result_o.moved   = st_q[S_OUT].moved;
  assign result_o.updated = st_q[S_OUT].upd;

  // A pose is only integrated for an updated dynamic body.
  a_moved_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[S_OUT] && st_q[S_OUT].moved) |-> st_q[S_OUT].upd)
    else $error("moved result without update");

  a_moved_dyn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[S_OUT] && st_q[S_OUT].moved) |-> (st_q[S_OUT].mode == rbi_pkg::MODE_DYNAMIC))
    else $error("moved result for a non-dynamic body");

  // An accepted record lands in the first stage.
  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (body_i.valid && body_i.ready) |=> v_q[S_IN])
    else $error("accepted record not captured");

  // A stall keeps every stage's occupancy.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (v_q == $past(v_q)))
    else $error("pipeline moved during a stall");

endmodule
